/* src/switch_edge_hold_repeat_assert.svh */
// Assertion macros for the switch edge/hold-repeat checker.
// Needs nothing else; the including file supplies clock, reset and expressions.
`ifndef SWITCH_EDGE_HOLD_REPEAT_ASSERT_SVH
`define SWITCH_EDGE_HOLD_REPEAT_ASSERT_SVH

// same-cycle implication
`define SEHR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sehr assertion failed");

// next-cycle implication
`define SEHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sehr assertion failed");

`endif

/* src/sehr_pkg.sv */
// Shared types, constants and helpers for the switch edge/hold-repeat block.
// No dependencies.
`timescale 1ns / 1ps

package sehr_pkg;

   // timer idle sentinel and duration limits
   localparam int REPEAT_IDLE    = 65535;
   localparam int ACTIVE_LIMIT   = 1023;
   localparam int INACTIVE_LIMIT = 1023;

   localparam int CNT_W    = 10;
   localparam int TIMER_W  = 16;
   localparam int CNT_MAX  = (1 << CNT_W) - 1;

   localparam logic [CNT_W-1:0] ACT_LIM =
      CNT_W'((ACTIVE_LIMIT > CNT_MAX) ? CNT_MAX : ACTIVE_LIMIT);
   localparam logic [CNT_W-1:0] INACT_LIM =
      CNT_W'((INACTIVE_LIMIT > CNT_MAX) ? CNT_MAX : INACTIVE_LIMIT);
   localparam logic [TIMER_W-1:0] TIMER_IDLE = TIMER_W'(REPEAT_IDLE);
   localparam logic [TIMER_W-1:0] TIMER_TOP  = TIMER_W'(REPEAT_IDLE - 1);

   // rise_result codes
   localparam logic [1:0] RISE_NONE    = 2'd0;
   localparam logic [1:0] RISE_ON      = 2'd1;
   localparam logic [1:0] RISE_BLOCKED = 2'd2;

   // fall_result codes
   localparam logic [1:0] FALL_NONE    = 2'd0;
   localparam logic [1:0] FALL_VALID   = 2'd1;
   localparam logic [1:0] FALL_INVALID = 2'd2;

   // register indexes
   localparam logic REG_START_DELAY   = 1'b0;
   localparam logic REG_REPEAT_PERIOD = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic pressed;
      logic rise_condition;
      logic fall_condition;
      logic start_condition;
      logic hold_condition;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         rise_result;
      logic [1:0]         fall_result;
      logic               repeat_pulse;
      logic [CNT_W-1:0]   press_ticks;
      logic [CNT_W-1:0]   release_ticks;
   } rsp_payload_type;

   typedef struct packed {
      logic [TIMER_W-1:0] start_delay;
      logic [TIMER_W-1:0] repeat_period;
   } cfg_type;

   typedef struct packed {
      logic               level;
      logic [CNT_W-1:0]   press_count;
      logic [CNT_W-1:0]   release_count;
      logic [TIMER_W-1:0] repeat_timer;
      logic               off_armed;
   } state_type;

   function automatic logic [TIMER_W-1:0] clamp_time(input logic [TIMER_W-1:0] t);
      return (t < TIMER_TOP) ? t : TIMER_TOP;
   endfunction

endpackage

/* src/sehr_csr.sv */
// APB-style register file: start_delay and repeat_period.
// Depends on sehr_pkg.
`timescale 1ns / 1ps

module sehr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sehr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sehr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sehr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output sehr_pkg::cfg_type                   cfg
);

   sehr_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // word decode on address bit 2; low bits ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            sehr_pkg::REG_START_DELAY:
               cfg_in.start_delay = csr_pwdata[sehr_pkg::TIMER_W-1:0];
            sehr_pkg::REG_REPEAT_PERIOD:
               cfg_in.repeat_period = csr_pwdata[sehr_pkg::TIMER_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sehr_pkg::REG_START_DELAY:
            csr_prdata = sehr_pkg::CSR_DATA_W'(cfg_ff.start_delay);
         sehr_pkg::REG_REPEAT_PERIOD:
            csr_prdata = sehr_pkg::CSR_DATA_W'(cfg_ff.repeat_period);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/sehr_step.sv */
// One-tick update: duration counters, edge results, armed flag, repeat timer.
// Depends on sehr_pkg.
`timescale 1ns / 1ps

module sehr_step (
   input  sehr_pkg::state_type        state,
   input  sehr_pkg::req_payload_type  req,
   input  sehr_pkg::cfg_type          cfg,
   output sehr_pkg::state_type        state_next,
   output sehr_pkg::rsp_payload_type  rsp
);

   logic                           rising;
   logic                           falling;
   logic                           armed_kept;
   logic [sehr_pkg::CNT_W-1:0]     press_cnt;
   logic [sehr_pkg::CNT_W-1:0]     release_cnt;
   logic [sehr_pkg::TIMER_W-1:0]   timer;
   logic [sehr_pkg::TIMER_W-1:0]   reload;
   logic                           pulse;

   assign rising  = req.pressed && !state.level;
   assign falling = !req.pressed && state.level;
   // a low fall_condition disarms before the falling edge is judged
   assign armed_kept = req.fall_condition && state.off_armed;

   always_comb begin
      press_cnt   = state.press_count;
      release_cnt = state.release_count;
      if (req.pressed) begin
         if (press_cnt < sehr_pkg::ACT_LIM) press_cnt = press_cnt + 1'b1;
      end else begin
         if (release_cnt < sehr_pkg::INACT_LIM) release_cnt = release_cnt + 1'b1;
      end
      // clear on the opposite previous level
      if (!state.level) begin
         press_cnt = '0;
      end else begin
         release_cnt = '0;
      end
   end

   always_comb begin
      timer  = state.repeat_timer;
      reload = sehr_pkg::clamp_time(cfg.repeat_period);
      pulse  = 1'b0;
      if (!req.pressed || !req.start_condition ||
          (!req.hold_condition && state.repeat_timer != sehr_pkg::TIMER_IDLE)) begin
         timer = sehr_pkg::TIMER_IDLE;
      end else if (state.repeat_timer == sehr_pkg::TIMER_IDLE && rising) begin
         timer = sehr_pkg::clamp_time(cfg.start_delay);
      end else begin
         if (timer != '0 && timer != sehr_pkg::TIMER_IDLE && req.hold_condition)
            timer = timer - 1'b1;
         if (timer == '0) begin
            // zero period: single pulse, then back to idle
            timer = (reload == '0) ? sehr_pkg::TIMER_IDLE : reload;
            pulse = 1'b1;
         end
      end
   end

   always_comb begin
      state_next.level         = req.pressed;
      state_next.press_count   = press_cnt;
      state_next.release_count = release_cnt;
      state_next.repeat_timer  = timer;
      state_next.off_armed     = (!req.pressed && req.fall_condition) ? 1'b1 : armed_kept;

      rsp.rise_result   = !rising ? sehr_pkg::RISE_NONE :
                          (req.rise_condition ? sehr_pkg::RISE_ON : sehr_pkg::RISE_BLOCKED);
      rsp.fall_result   = !falling ? sehr_pkg::FALL_NONE :
                          (armed_kept ? sehr_pkg::FALL_VALID : sehr_pkg::FALL_INVALID);
      rsp.repeat_pulse  = pulse;
      rsp.press_ticks   = press_cnt;
      rsp.release_ticks = release_cnt;
   end

endmodule

/* src/switch_edge_hold_repeat.sv */
// Top level of the switch edge detector with hold auto-repeat.
// Depends on sehr_pkg, sehr_csr and sehr_step.
//
// Each req_ transfer is one tick of switch sampling and produces exactly one
// rsp_ transfer. While rsp_ready is high the block sustains one transfer per
// clock: the tick update is a single pass of logic from the accepted request
// into the state and result registers, so throughput is set only by
// that one result register. req_ready drops only while a result is held
// waiting for rsp_ready; a held result does not block the next request once
// rsp_ready is high in the same cycle. Registers start_delay (offset 0x0)
// and repeat_period (offset 0x4) are written through the csr_ port and
// should only be changed while no tick is in flight. After reset the
// release count reads at its limit and the repeat timer is idle.
`timescale 1ns / 1ps

module switch_edge_hold_repeat (
   input  logic                                clock,
   input  logic                                reset,
   // tick request
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sehr_pkg::req_payload_type           req_data,
   // tick result
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sehr_pkg::rsp_payload_type           rsp_data,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sehr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sehr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sehr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   sehr_pkg::cfg_type          cfg;
   sehr_pkg::state_type        state_ff, state_in, state_next;
   sehr_pkg::rsp_payload_type  rsp_ff, rsp_in, rsp_next;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_xfer;

   sehr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sehr_step u_step (
      .state      (state_ff),
      .req        (req_data),
      .cfg        (cfg),
      .state_next (state_next),
      .rsp        (rsp_next)
   );

   // result slot is free when empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in     = req_xfer ? state_next : state_ff;
      rsp_in       = req_xfer ? rsp_next : rsp_ff;
      rsp_valid_in = req_xfer ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.level         <= 1'b0;
         state_ff.press_count   <= '0;
         state_ff.release_count <= sehr_pkg::INACT_LIM;
         state_ff.repeat_timer  <= sehr_pkg::TIMER_IDLE;
         state_ff.off_armed     <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/sehr_checker.sv */
// Port-level checker for switch_edge_hold_repeat, bound to the top level.
// Depends on sehr_pkg and switch_edge_hold_repeat_assert.svh.
`timescale 1ns / 1ps
`include "switch_edge_hold_repeat_assert.svh"

module sehr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input sehr_pkg::rsp_payload_type  rsp_data
);

   // held result stays put
   `SEHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // backpressure only from a stalled result
   `SEHR_ASSERT_NOW(a_ready_src, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // press tick reports a cleared press count
   `SEHR_ASSERT_NOW(a_rise_cnt, clock, reset, rsp_valid && rsp_data.rise_result != sehr_pkg::RISE_NONE, rsp_data.press_ticks == '0)

   // release tick reports a cleared release count
   `SEHR_ASSERT_NOW(a_fall_cnt, clock, reset, rsp_valid && rsp_data.fall_result != sehr_pkg::FALL_NONE, rsp_data.release_ticks == '0)

endmodule

bind switch_edge_hold_repeat sehr_checker u_sehr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/switch_edge_hold_repeat_test.sv */
// Testbench for switch_edge_hold_repeat: a tick scoreboard class and the test top.
// Depends on sehr_pkg and the switch_edge_hold_repeat RTL.
`timescale 1ns / 1ps

class tick_scoreboard;
   sehr_pkg::rsp_payload_type expected_ticks[$];

   // register copies
   logic [15:0] start_delay;
   logic [15:0] repeat_period;

   // tracked block state
   logic        level_now;
   logic        level_before;
   logic        off_armed;
   logic [9:0]  press_count;
   logic [9:0]  release_count;
   logic [15:0] repeat_timer;

   int mismatches;
   int checked;
   int rises;
   int falls;
   int pulses;

   function new();
      start_delay   = '0;
      repeat_period = '0;
      level_now     = 1'b0;
      level_before  = 1'b0;
      off_armed     = 1'b0;
      press_count   = '0;
      release_count = sehr_pkg::INACT_LIM;
      repeat_timer  = sehr_pkg::TIMER_IDLE;
      mismatches    = 0;
      checked       = 0;
      rises         = 0;
      falls         = 0;
      pulses        = 0;
   endfunction

   // times stop one short of the idle value
   function logic [15:0] below_idle(logic [15:0] t);
      return (t < sehr_pkg::TIMER_TOP) ? t : sehr_pkg::TIMER_TOP;
   endfunction

   function void set_register(logic reg_index, logic [15:0] value);
      if (reg_index == sehr_pkg::REG_START_DELAY) begin
         start_delay = value;
      end else begin
         repeat_period = value;
      end
   endfunction

   // one tick of the switch logic; queues the result it must produce
   function void predict_tick(sehr_pkg::req_payload_type t);
      sehr_pkg::rsp_payload_type r;
      logic was_pressed;
      logic rising;
      logic falling;
      r = '0;
      r.rise_result = sehr_pkg::RISE_NONE;
      r.fall_result = sehr_pkg::FALL_NONE;
      was_pressed = level_now;
      level_before = level_now;
      level_now = t.pressed;
      if (t.pressed) begin
         if (press_count < sehr_pkg::ACT_LIM) press_count++;
      end else if (release_count < sehr_pkg::INACT_LIM) begin
         release_count++;
      end
      // count restarts on the edge tick itself
      if (!was_pressed) begin
         press_count = '0;
      end else begin
         release_count = '0;
      end
      rising  = level_now && !level_before;
      falling = !level_now && level_before;

      if (rising) begin
         r.rise_result = t.rise_condition ? sehr_pkg::RISE_ON : sehr_pkg::RISE_BLOCKED;
      end

      if (!t.fall_condition) off_armed = 1'b0;
      if (falling) begin
         r.fall_result = (t.fall_condition && off_armed) ? sehr_pkg::FALL_VALID
                                                         : sehr_pkg::FALL_INVALID;
      end
      if (!level_now && t.fall_condition) off_armed = 1'b1;

      if (!level_now || !t.start_condition ||
          (!t.hold_condition && repeat_timer != sehr_pkg::TIMER_IDLE)) begin
         repeat_timer = sehr_pkg::TIMER_IDLE;
      end else if (repeat_timer == sehr_pkg::TIMER_IDLE && rising) begin
         repeat_timer = below_idle(start_delay);
      end else begin
         if (repeat_timer != '0 && repeat_timer != sehr_pkg::TIMER_IDLE &&
             t.hold_condition) begin
            repeat_timer--;
         end
         if (repeat_timer == '0) begin
            repeat_timer = below_idle(repeat_period);
            if (repeat_timer == '0) repeat_timer = sehr_pkg::TIMER_IDLE;
            r.repeat_pulse = 1'b1;
         end
      end

      r.press_ticks   = press_count;
      r.release_ticks = release_count;
      expected_ticks.push_back(r);
   endfunction

   task report_mismatch(string msg);
      $display("ERROR: result %0d: %s", checked, msg);
      mismatches++;
   endtask

   task compare_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
      end
   endtask

   task check_result(sehr_pkg::rsp_payload_type got);
      sehr_pkg::rsp_payload_type want;
      if (expected_ticks.size() == 0) begin
         report_mismatch($sformatf("result 0x%0h with no tick outstanding", got));
      end else begin
         want = expected_ticks.pop_front();
         compare_field("rise_result", 16'(got.rise_result), 16'(want.rise_result));
         compare_field("fall_result", 16'(got.fall_result), 16'(want.fall_result));
         compare_field("repeat_pulse", 16'(got.repeat_pulse), 16'(want.repeat_pulse));
         compare_field("press_ticks", 16'(got.press_ticks), 16'(want.press_ticks));
         compare_field("release_ticks", 16'(got.release_ticks), 16'(want.release_ticks));
      end
      if (got.rise_result !== sehr_pkg::RISE_NONE) rises++;
      if (got.fall_result !== sehr_pkg::FALL_NONE) falls++;
      if (got.repeat_pulse === 1'b1) pulses++;
      checked++;
   endtask
endclass

module switch_edge_hold_repeat_test;

   localparam int STALL_LIMIT        = 2000;  // cycles without any transfer
   localparam int TAIL_CYCLES        = 8;
   localparam int RANDOM_PER_SETTING = 80;
   localparam int OPENING_SPLIT      = 17;    // registers change before this tick

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sehr_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   sehr_pkg::rsp_payload_type rsp_data;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [sehr_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [sehr_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [sehr_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   tick_scoreboard book = new;

   // idle odds, in percent, changed per phase by the main sequence
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int settings_used = 0;
   int stall_cycles = 0;

   // Opening ticks, {pressed, rise, fall, start, hold}. They walk through
   // both rise codes, a valid release after an armed released stretch,
   // releases with the arm cleared, zero delay with its single pulse, a timer
   // stop by the hold condition, a held level with the timer idle and not
   // counting, and after the register change a delay/period run that a
   // dropped hold condition cuts short.
   logic [4:0] opening_ticks [0:23] = '{
      5'b01111, 5'b11111, 5'b11111, 5'b10111, 5'b00111, 5'b10011,
      5'b10110, 5'b01100, 5'b01000, 5'b11101, 5'b11111, 5'b01111,
      5'b01111, 5'b11111, 5'b01111, 5'b10000, 5'b00000,
      5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11110, 5'b11111, 5'b00111
   };

   // register settings for the random part; the last one is drawn at run time
   logic [15:0] delay_choice  [0:5] = '{16'd0, 16'd0, 16'd1, 16'd3, 16'd60000, 16'd0};
   logic [15:0] period_choice [0:5] = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd60000, 16'd0};

   switch_edge_hold_repeat dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   // Transfers are sampled at the edge, before this edge's updates land.
   // The result check goes first: a tick accepted now cannot have its
   // result out in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) book.check_result(rsp_data);
         if (req_valid && req_ready) book.predict_tick(req_data);
      end
   end

   // watchdog: any transfer on either channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
         $display("switch_edge_hold_repeat test failed");
         $finish;
      end
   end

   // Random gap first, then hold valid and data until the transfer.
   // Valid only drops when a gap is taken, never in the raising step.
   task send_tick(input sehr_pkg::req_payload_type t);
      while ($urandom_range(99, 0) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender holds off until every queued result has come back
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.expected_ticks.size() != 0) @(posedge clock);
   endtask

   // setup cycle, access cycle; the write lands at the edge ending access
   task write_register(input logic reg_index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      book.set_register(reg_index, value);
   endtask

   task program_setting(input logic [15:0] delay, input logic [15:0] period);
      write_register(sehr_pkg::REG_START_DELAY, delay);
      write_register(sehr_pkg::REG_REPEAT_PERIOD, period);
      settings_used++;
   endtask

   // The fall, start and hold conditions are mostly true so the timer and arm flag get somewhere;
   // a noisy tick has every bit drawn flat.
   function sehr_pkg::req_payload_type make_tick(input logic level, input logic noisy);
      sehr_pkg::req_payload_type t;
      if (noisy) begin
         t = sehr_pkg::req_payload_type'(5'($urandom_range(31, 0)));
      end else begin
         t.pressed         = level;
         t.rise_condition  = 1'($urandom_range(1, 0));
         t.fall_condition  = ($urandom_range(9, 0) != 0);
         t.start_condition = ($urandom_range(19, 0) != 0);
         t.hold_condition  = ($urandom_range(14, 0) != 0);
      end
      return t;
   endfunction

   // press/release bursts of random length, with some noise bursts mixed in
   task run_random(input int count);
      int sent;
      int kind;
      int press_len;
      int release_len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9, 0);
         if (kind == 0) begin
            repeat ($urandom_range(6, 1)) begin
               send_tick(make_tick(1'b0, 1'b1));
               sent++;
            end
         end else begin
            press_len   = (kind == 1) ? $urandom_range(40, 1) : $urandom_range(12, 1);
            release_len = $urandom_range(8, 1);
            repeat (press_len) send_tick(make_tick(1'b1, 1'b0));
            repeat (release_len) send_tick(make_tick(1'b0, 1'b0));
            sent += press_len + release_len;
         end
      end
   endtask

   initial begin
      int phase;
      int k;
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // opening ticks under slow sender, slower receiver
      req_gap_pct   = 33;
      rsp_stall_pct = 77;
      program_setting(16'd0, 16'd0);
      for (k = 0; k < 24; k++) begin
         if (k == OPENING_SPLIT) begin
            drain();
            program_setting(16'd2, 16'd1);
         end
         send_tick(sehr_pkg::req_payload_type'(opening_ticks[k]));
      end

      delay_choice[5]  = 16'($urandom_range(12, 0));
      period_choice[5] = 16'($urandom_range(12, 0));

      // three idling phases, two register settings each
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct   = 33;
               rsp_stall_pct = 77;
            end
            1: begin
               req_gap_pct   = 77;
               rsp_stall_pct = 33;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (k = 0; k < 2; k++) begin
            pick = 2 * phase + k;
            drain();
            program_setting(delay_choice[pick], period_choice[pick]);
            run_random(RANDOM_PER_SETTING);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d tick results across %0d register settings and three idle mixes.",
               book.checked, settings_used);
      $display("Results carried %0d rising edges, %0d falling edges, %0d repeat pulses.",
               book.rises, book.falls, book.pulses);
      if (book.mismatches == 0 && book.expected_ticks.size() == 0) begin
         $display("switch_edge_hold_repeat test passed");
      end else begin
         $display("switch_edge_hold_repeat test failed");
      end
      $finish;
   end

endmodule

/* switch_edge_hold_repeat.f */
+incdir+src
src/sehr_pkg.sv
src/sehr_csr.sv
src/sehr_step.sv
src/switch_edge_hold_repeat.sv
src/sehr_checker.sv
tb/sv/switch_edge_hold_repeat_test.sv
